// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while the block is out of reset.
`define ETHJH_ASSERT_RUN(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define ETHJH_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hw/rtl/ethjh_pkg.sv =====
`timescale 1ns / 1ps

package ethjh_pkg;

  localparam int SYMBOLS        = 16;
  localparam int MAX_THRESHOLDS = 20;
  localparam int MAX_PERIOD     = 8;
  localparam int RECV_CODES     = SYMBOLS + 1;
  localparam int STORE_DEPTH    = MAX_THRESHOLDS * MAX_PERIOD * SYMBOLS * RECV_CODES;

  localparam int SYM_W      = 4;
  localparam int PROB_W     = 16;
  localparam int THR_W      = 5;
  localparam int POS_W      = 3;
  localparam int RECV_W     = 5;
  localparam int PER_W      = 4;
  localparam int COUNT_W    = 32;
  localparam int CELL_W     = THR_W + POS_W + SYM_W;
  localparam int ADDR_W     = $clog2(STORE_DEPTH);
  localparam int ACC_W      = PROB_W + $clog2(MAX_THRESHOLDS + 1);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [THR_W-1:0]   THR_COUNT_RST = THR_W'(20);
  localparam logic [PROB_W-1:0]  THR_STEP_RST  = PROB_W'(3277);
  localparam logic [PER_W-1:0]   PERIOD_RST    = PER_W'(1);
  localparam logic [PROB_W-1:0]  PROB_ONE      = '1;
  localparam logic [COUNT_W-1:0] COUNT_MAX     = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD_COUNT = 2'd0,
    CFG_THRESHOLD_STEP  = 2'd1,
    CFG_POSITION_PERIOD = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    KIND_ELEMENT = 1'b0,
    KIND_READ    = 1'b1
  } item_kind_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_SEG
  } back_state_t;

  typedef struct packed {
    logic                is_read;
    logic [ADDR_W-1:0]   addr;
    logic                oob;
    logic [PROB_W-1:0]   max;
    logic [SYM_W-1:0]    argmax;
    logic [SYM_W-1:0]    sent;
    logic [POS_W-1:0]    pos;
    logic [THR_W-1:0]    count;
    logic [PROB_W-1:0]   step;
  } ethjh_job_t;

  typedef struct packed {
    logic empty;
    logic full;
  } ethjh_q_stat_t;

  // Linear counter index ((t * MAX_PERIOD + p) * SYMBOLS + s) * RECV_CODES + r.
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [THR_W-1:0]  t,
                                                  input logic [POS_W-1:0]  p,
                                                  input logic [SYM_W-1:0]  s,
                                                  input logic [RECV_W-1:0] r);
    logic [CELL_W-1:0]   x;
    logic [ADDR_W+1:0]   sum;
    x   = {t, p, s};
    sum = {2'b00, x, 4'b0000} + (ADDR_W + 2)'(x) + (ADDR_W + 2)'(r);
    return sum[ADDR_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/ethjh_ram.sv =====
`timescale 1ns / 1ps

module ethjh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/ethjh_front.sv =====
`timescale 1ns / 1ps

module ethjh_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_kind,
  input  logic [ethjh_pkg::SYM_W-1:0]    in_true_symbol,
  input  logic [ethjh_pkg::PROB_W-1:0]   in_prob,
  input  logic [ethjh_pkg::SYM_W-1:0]    in_elem_index,
  input  logic                           in_first_segment,
  input  logic [ethjh_pkg::THR_W-1:0]    in_rd_threshold,
  input  logic [ethjh_pkg::POS_W-1:0]    in_rd_position,
  input  logic [ethjh_pkg::SYM_W-1:0]    in_rd_sent,
  input  logic [ethjh_pkg::RECV_W-1:0]   in_rd_received,
  input  logic                           cfg_we,
  input  logic [ethjh_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ethjh_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  ethjh_pkg::ethjh_q_stat_t       q_stat,
  input  logic                           clearing,
  output logic                           push,
  output ethjh_pkg::ethjh_job_t          push_job
);

  import ethjh_pkg::*;

  localparam logic [SYM_W:0] SYM_LIMIT = (SYM_W + 1)'(SYMBOLS);

  logic [THR_W-1:0]  cfg_count_r;
  logic [PROB_W-1:0] cfg_step_r;
  logic [PER_W-1:0]  cfg_period_r;

  logic [PROB_W-1:0] running_max_r, running_max_nxt;
  logic [SYM_W-1:0]  running_argmax_r, running_argmax_nxt;
  logic [POS_W-1:0]  seg_pos_r, seg_pos_nxt;

  logic              accept;
  logic              is_read;
  logic              idx_ok;
  logic              seg_end;
  logic              sent_ok;
  logic              elem_take;
  logic              max_upd;
  logic [PROB_W-1:0] new_max;
  logic [SYM_W-1:0]  new_arg;
  logic [PER_W-1:0]  per_eff;
  logic [THR_W-1:0]  count_eff;
  logic [POS_W-1:0]  pos_sel;
  logic [POS_W-1:0]  pos_use;
  logic [PER_W-1:0]  pos_inc;
  logic [POS_W-1:0]  pos_next;
  logic              rd_oob;

  assign busy    = clearing || q_stat.full;
  assign accept  = start && !busy;
  assign is_read = (in_kind == KIND_READ);
  assign idx_ok  = ((SYM_W + 1)'(in_elem_index) < SYM_LIMIT);
  assign seg_end = (in_elem_index == SYM_W'(SYMBOLS - 1));
  assign sent_ok = ((SYM_W + 1)'(in_true_symbol) < SYM_LIMIT);
  assign elem_take = accept && !is_read && idx_ok;

  assign max_upd = (in_elem_index == '0) || (in_prob > running_max_r);
  assign new_max = max_upd ? in_prob : running_max_r;
  assign new_arg = max_upd ? in_elem_index : running_argmax_r;

  always_comb begin
    if (cfg_period_r == '0) begin
      per_eff = PER_W'(1);
    end else if (cfg_period_r > PER_W'(MAX_PERIOD)) begin
      per_eff = PER_W'(MAX_PERIOD);
    end else begin
      per_eff = cfg_period_r;
    end
    if (cfg_count_r == '0) begin
      count_eff = THR_W'(1);
    end else if (cfg_count_r > THR_W'(MAX_THRESHOLDS)) begin
      count_eff = THR_W'(MAX_THRESHOLDS);
    end else begin
      count_eff = cfg_count_r;
    end
  end

  assign pos_sel  = in_first_segment ? '0 : seg_pos_r;
  assign pos_use  = (PER_W'(pos_sel) >= per_eff) ? '0 : pos_sel;
  assign pos_inc  = PER_W'(pos_use) + PER_W'(1);
  assign pos_next = (pos_inc >= per_eff) ? '0 : pos_inc[POS_W-1:0];

  assign rd_oob = (in_rd_threshold >= THR_W'(MAX_THRESHOLDS)) ||
                  (PER_W'(in_rd_position) >= PER_W'(MAX_PERIOD)) ||
                  ((SYM_W + 1)'(in_rd_sent) >= SYM_LIMIT) ||
                  (in_rd_received > RECV_W'(SYMBOLS));

  assign push = accept && (is_read || (idx_ok && seg_end && sent_ok));

  always_comb begin
    push_job         = '0;
    push_job.is_read = is_read;
    push_job.oob     = rd_oob;
    push_job.addr    = rd_oob ? '0 : cell_addr(in_rd_threshold, in_rd_position,
                                               in_rd_sent, in_rd_received);
    push_job.max     = new_max;
    push_job.argmax  = new_arg;
    push_job.sent    = in_true_symbol;
    push_job.pos     = pos_use;
    push_job.count   = count_eff;
    push_job.step    = cfg_step_r;
  end

  always_comb begin
    running_max_nxt    = running_max_r;
    running_argmax_nxt = running_argmax_r;
    seg_pos_nxt        = seg_pos_r;
    if (elem_take) begin
      running_max_nxt    = new_max;
      running_argmax_nxt = new_arg;
      if (seg_end) begin
        seg_pos_nxt = pos_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_max_r    <= '0;
      running_argmax_r <= '0;
      seg_pos_r        <= '0;
    end else begin
      running_max_r    <= running_max_nxt;
      running_argmax_r <= running_argmax_nxt;
      seg_pos_r        <= seg_pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_count_r  <= THR_COUNT_RST;
      cfg_step_r   <= THR_STEP_RST;
      cfg_period_r <= PERIOD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_THRESHOLD_COUNT: begin
          cfg_count_r <= cfg_wdata[THR_W-1:0];
        end
        CFG_THRESHOLD_STEP: begin
          cfg_step_r <= cfg_wdata[PROB_W-1:0];
        end
        CFG_POSITION_PERIOD: begin
          cfg_period_r <= cfg_wdata[PER_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/ethjh_fifo.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ethjh_fifo #(
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  input  ethjh_pkg::ethjh_job_t    push_job,
  input  logic                     pop,
  output ethjh_pkg::ethjh_job_t    head_job,
  output ethjh_pkg::ethjh_q_stat_t stat
);

  import ethjh_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  ethjh_job_t       mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push;
  logic             do_pop;

  assign stat.empty = (cnt_r == '0);
  assign stat.full  = (cnt_r == CNT_W'(DEPTH));
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head_job   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  `ETHJH_ASSERT_RUN(a_no_push_when_full, !(push && stat.full), "Queue written while full.")
  `ETHJH_ASSERT_RUN(a_no_pop_when_empty, !(pop && stat.empty), "Queue read while empty.")

endmodule

// ===== hw/rtl/ethjh_back.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ethjh_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  ethjh_pkg::ethjh_q_stat_t       q_stat,
  input  ethjh_pkg::ethjh_job_t          head_job,
  output logic                           pop,
  output logic                           clearing,
  output logic                           out_valid,
  output logic [ethjh_pkg::COUNT_W-1:0]  out_count_value
);

  import ethjh_pkg::*;

  back_state_t       state_r, state_nxt;
  logic [ADDR_W-1:0] clr_addr_r, clr_addr_nxt;
  logic [THR_W-1:0]  t_r, t_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  ethjh_job_t        job_r, job_nxt;

  logic               s1_valid_r, s1_read_r, s1_oob_r, s1_fwd_r;
  logic [ADDR_W-1:0]  s1_addr_r;
  logic [COUNT_W-1:0] s1_fwd_data_r;
  logic               out_valid_r;
  logic [COUNT_W-1:0] out_value_r;

  logic               issue_valid;
  logic               issue_read;
  logic               issue_oob;
  logic [ADDR_W-1:0]  issue_addr;
  logic               t_last;
  logic               acc_hi;
  logic [PROB_W:0]    sum;
  logic               erase;
  logic [RECV_W-1:0]  recv;
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [COUNT_W-1:0] ram_wdata;
  logic [COUNT_W-1:0] ram_rdata;
  logic [COUNT_W-1:0] s1_data;

  assign t_last = ((t_r + THR_W'(1)) == job_r.count);

  // A maximum of zero is erased once the threshold drops to one LSB; a zero
  // step leaves the threshold at full scale, which only 1.0 reaches.
  assign acc_hi = |acc_r[ACC_W-1:PROB_W];
  assign sum    = {1'b0, job_r.max} + {1'b0, acc_r[PROB_W-1:0]};
  always_comb begin
    if (acc_hi) begin
      erase = (job_r.max == '0);
    end else if (acc_r == '0) begin
      erase = (job_r.max != PROB_ONE);
    end else begin
      erase = !sum[PROB_W];
    end
  end
  assign recv = erase ? RECV_W'(SYMBOLS) : RECV_W'(job_r.argmax);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_CLEAR: begin
        if (clr_addr_r == ADDR_W'(STORE_DEPTH - 1)) begin
          state_nxt = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (!q_stat.empty && !head_job.is_read) begin
          state_nxt = BK_SEG;
        end
      end
      BK_SEG: begin
        if (t_last) begin
          state_nxt = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_comb begin
    pop          = 1'b0;
    clearing     = 1'b0;
    issue_valid  = 1'b0;
    issue_read   = 1'b0;
    issue_oob    = 1'b0;
    issue_addr   = '0;
    clr_addr_nxt = clr_addr_r;
    t_nxt        = t_r;
    acc_nxt      = acc_r;
    job_nxt      = job_r;
    case (state_r)
      BK_CLEAR: begin
        clearing     = 1'b1;
        clr_addr_nxt = clr_addr_r + ADDR_W'(1);
      end
      BK_IDLE: begin
        pop     = !q_stat.empty;
        t_nxt   = '0;
        acc_nxt = ACC_W'(head_job.step);
        if (pop) begin
          job_nxt = head_job;
          if (head_job.is_read) begin
            issue_valid = 1'b1;
            issue_read  = 1'b1;
            issue_oob   = head_job.oob;
            issue_addr  = head_job.addr;
          end
        end
      end
      BK_SEG: begin
        issue_valid = 1'b1;
        issue_addr  = cell_addr(t_r, job_r.pos, job_r.sent, recv);
        t_nxt       = t_r + THR_W'(1);
        acc_nxt     = acc_r + ACC_W'(job_r.step);
      end
      default: begin
      end
    endcase
  end

  assign s1_data = s1_fwd_r ? s1_fwd_data_r : ram_rdata;

  always_comb begin
    if (state_r == BK_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_r;
      ram_wdata = '0;
    end else begin
      ram_we    = s1_valid_r && !s1_read_r;
      ram_waddr = s1_addr_r;
      ram_wdata = (s1_data == COUNT_MAX) ? s1_data : s1_data + COUNT_W'(1);
    end
  end

  ethjh_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (issue_addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_CLEAR;
      clr_addr_r  <= '0;
      t_r         <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      t_r         <= t_nxt;
      s1_valid_r  <= issue_valid;
      out_valid_r <= s1_valid_r && s1_read_r;
    end
  end

  always_ff @(posedge clk) begin
    acc_r         <= acc_nxt;
    job_r         <= job_nxt;
    s1_read_r     <= issue_read;
    s1_oob_r      <= issue_oob;
    s1_addr_r     <= issue_addr;
    s1_fwd_r      <= ram_we && (ram_waddr == issue_addr);
    s1_fwd_data_r <= ram_wdata;
    out_value_r   <= s1_oob_r ? '0 : s1_data;
  end

  assign out_valid       = out_valid_r;
  assign out_count_value = out_value_r;

  `ETHJH_ASSERT_RUN(a_result_from_read, out_valid_r |-> $past(s1_valid_r && s1_read_r), "Result strobe without a read in flight.")
  `ETHJH_ASSERT_RUN(a_seg_count_nonzero, (state_r == BK_SEG) |-> (job_r.count != '0), "Segment job with no thresholds.")
  `ETHJH_ASSERT_ALWAYS(a_reset_starts_clear, !rst_n |=> (state_r == BK_CLEAR), "Reset did not start the clearing pass.")

endmodule

// ===== hw/rtl/erasure_threshold_joint_histogram.sv =====
// A read item passes the queue, the registered store read and the output register
// before its result is strobed; behind queued segments it waits until each segment's
// counter updates are done. One item per cycle is taken while the 4-entry queue has
// room and no clearing runs; the counter unit does one read-modify-write a cycle.
// Reset: a clearing pass zeroes every counter, one counter a cycle, keeps busy high.
`timescale 1ns / 1ps

module erasure_threshold_joint_histogram (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic                             in_kind,
  input  logic [ethjh_pkg::SYM_W-1:0]      in_true_symbol,
  input  logic [ethjh_pkg::PROB_W-1:0]     in_prob,
  input  logic [ethjh_pkg::SYM_W-1:0]      in_elem_index,
  input  logic                             in_first_segment,
  input  logic [ethjh_pkg::THR_W-1:0]      in_rd_threshold,
  input  logic [ethjh_pkg::POS_W-1:0]      in_rd_position,
  input  logic [ethjh_pkg::SYM_W-1:0]      in_rd_sent,
  input  logic [ethjh_pkg::RECV_W-1:0]     in_rd_received,
  output logic                             out_valid,
  output logic [ethjh_pkg::COUNT_W-1:0]    out_count_value,
  input  logic                             cfg_we,
  input  logic [ethjh_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ethjh_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  import ethjh_pkg::*;

  ethjh_q_stat_t q_stat;
  ethjh_job_t    push_job;
  ethjh_job_t    head_job;
  logic          push;
  logic          pop;
  logic          clearing;

  ethjh_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_kind          (in_kind),
    .in_true_symbol   (in_true_symbol),
    .in_prob          (in_prob),
    .in_elem_index    (in_elem_index),
    .in_first_segment (in_first_segment),
    .in_rd_threshold  (in_rd_threshold),
    .in_rd_position   (in_rd_position),
    .in_rd_sent       (in_rd_sent),
    .in_rd_received   (in_rd_received),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .q_stat           (q_stat),
    .clearing         (clearing),
    .push             (push),
    .push_job         (push_job)
  );

  ethjh_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .stat     (q_stat)
  );

  ethjh_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_stat          (q_stat),
    .head_job        (head_job),
    .pop             (pop),
    .clearing        (clearing),
    .out_valid       (out_valid),
    .out_count_value (out_count_value)
  );

endmodule
